// File: rtl/core/sst_pkg.sv
package sst_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int AXES       = 3;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    // Outcome codes carried on m_tuser.
    localparam logic [1:0] TRIM_NONE  = 2'd0;
    localparam logic [1:0] TRIM_START = 2'd1;
    localparam logic [1:0] TRIM_END   = 2'd2;
    localparam logic [1:0] TRIM_ZERO  = 2'd3;

    // Both endpoints, axis 0 in the lowest bits.
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] e;
        logic [AXES-1:0][COORD_W-1:0] s;
    } pay_t;

    // Side data that travels beside the square root stages.
    typedef struct packed {
        pay_t                         pay;
        logic [1:0]                   outcome;
        logic [AXES-1:0]              neg;
        logic [AXES-1:0][COORD_W:0]   mag;
    } mid_t;

    // Side data that travels beside the divider stages.
    typedef struct packed {
        pay_t            pay;
        logic [1:0]      outcome;
        logic [AXES-1:0] neg;
    } tail_t;

endpackage

// File: rtl/core/sst_isqrt.sv
module sst_isqrt import sst_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] x_in,
    output logic [31:0] root
);

    logic [63:0] x_reg   [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS];

    // One digit of the bitwise square root per stage, highest digit first.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [63:0] x_cur;
        logic [63:0] res_cur;
        logic [63:0] bit_val;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign x_cur   = x_in;
            assign res_cur = '0;
        end else begin : g_next
            assign x_cur   = x_reg[k-1];
            assign res_cur = res_reg[k-1];
        end

        assign bit_val = 64'd1 << (62 - 2 * k);
        assign trial   = res_cur + bit_val;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (x_cur >= trial) begin
                    x_reg[k]   <= x_cur - trial;
                    res_reg[k] <= (res_cur >> 1) + bit_val;
                end else begin
                    x_reg[k]   <= x_cur;
                    res_reg[k] <= res_cur >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][31:0];

endmodule

// File: rtl/core/sst_div.sv
module sst_div import sst_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] den_in,
    input  logic [32:0] rem_in,
    input  logic [31:0] low_in,
    output logic [31:0] quo
);

    logic [32:0] rem_reg [DIV_STEPS];
    logic [31:0] low_reg [DIV_STEPS];
    logic [31:0] quo_reg [DIV_STEPS];
    logic [32:0] den_reg [DIV_STEPS];

    // Restoring division, one quotient bit per stage. The starting remainder
    // is always below the divisor, so the remainder fits in 33 bits.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0] rem_cur;
        logic [31:0] low_cur;
        logic [31:0] quo_cur;
        logic [32:0] den_cur;
        logic [33:0] shifted;
        logic [33:0] diff;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_cur = rem_in;
            assign low_cur = low_in;
            assign quo_cur = '0;
            assign den_cur = den_in;
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign low_cur = low_reg[k-1];
            assign quo_cur = quo_reg[k-1];
            assign den_cur = den_reg[k-1];
        end

        assign shifted = {rem_cur, low_cur[31]};
        assign ge      = shifted >= {1'b0, den_cur};
        assign diff    = shifted - {1'b0, den_cur};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[32:0] : shifted[32:0];
                low_reg[k] <= {low_cur[30:0], 1'b0};
                quo_reg[k] <= {quo_cur[30:0], ge};
                den_reg[k] <= den_cur;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// File: rtl/core/segment_sphere_trim_unit.sv
// Throughput: one word per cycle; the whole pipeline moves together and
// holds only while a result waits at m_tdata with m_tready low.
// Depth is set by the 32 square root stages and the 32 divider stages.
// Reset: synchronous, active low; clears all valid bits, no result pending.
module segment_sphere_trim_unit import sst_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z,
    // center_x, center_y, center_z, sphere_radius, one zero pad bit
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_start_x, new_start_y, new_start_z, new_end_x, new_end_y, new_end_z
    output logic [191:0] m_tdata,
    // trim_outcome
    output logic [1:0]   m_tuser
);

    localparam int NST = 4 + SQRT_STEPS + 2 + DIV_STEPS + 1;

    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv      = m_tready | ~vld_reg[NST-1];
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // Stage 1: differences and magnitudes.
    pay_t                        in_pay;
    logic [AXES-1:0][COORD_W-1:0] in_c;
    logic [AXES-1:0][COORD_W:0]  ds, de, dv, ms_n, me_n, mv_n;

    assign in_pay.s = s_tdata[95:0];
    assign in_pay.e = s_tdata[191:96];
    assign in_c     = s_tdata[287:192];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            ds[i]   = {in_pay.s[i][31], in_pay.s[i]} - {in_c[i][31], in_c[i]};
            de[i]   = {in_pay.e[i][31], in_pay.e[i]} - {in_c[i][31], in_c[i]};
            dv[i]   = {in_pay.e[i][31], in_pay.e[i]} - {in_pay.s[i][31], in_pay.s[i]};
            ms_n[i] = ds[i][32] ? (~ds[i] + 33'd1) : ds[i];
            me_n[i] = de[i][32] ? (~de[i] + 33'd1) : de[i];
            mv_n[i] = dv[i][32] ? (~dv[i] + 33'd1) : dv[i];
        end
    end

    pay_t                       pay1_reg;
    logic                       zero1_reg;
    logic [AXES-1:0][COORD_W:0] ms1_reg, me1_reg, mv1_reg;
    logic [AXES-1:0]            vneg1_reg;
    logic [RAD_W-1:0]           r1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay1_reg  <= in_pay;
            zero1_reg <= (in_pay.s == in_pay.e);
            ms1_reg   <= ms_n;
            me1_reg   <= me_n;
            mv1_reg   <= mv_n;
            for (int i = 0; i < AXES; i++) begin
                vneg1_reg[i] <= dv[i][32];
            end
            r1_reg    <= s_tdata[318:288];
        end
    end

    // Stage 2: squares.
    pay_t                       pay2_reg;
    logic                       zero2_reg, fars2_reg, fare2_reg;
    logic [AXES-1:0][61:0]      sqs2_reg, sqe2_reg;
    logic [AXES-1:0][65:0]      sqv2_reg;
    logic [61:0]                r2_2_reg;
    logic [AXES-1:0][COORD_W:0] mv2_reg;
    logic [AXES-1:0]            vneg2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay2_reg  <= pay1_reg;
            zero2_reg <= zero1_reg;
            fars2_reg <= |{ms1_reg[0][32:31], ms1_reg[1][32:31], ms1_reg[2][32:31]};
            fare2_reg <= |{me1_reg[0][32:31], me1_reg[1][32:31], me1_reg[2][32:31]};
            for (int i = 0; i < AXES; i++) begin
                sqs2_reg[i] <= ms1_reg[i][30:0] * ms1_reg[i][30:0];
                sqe2_reg[i] <= me1_reg[i][30:0] * me1_reg[i][30:0];
                sqv2_reg[i] <= {33'd0, mv1_reg[i]} * {33'd0, mv1_reg[i]};
            end
            r2_2_reg  <= {31'd0, r1_reg} * {31'd0, r1_reg};
            mv2_reg   <= mv1_reg;
            vneg2_reg <= vneg1_reg;
        end
    end

    // Stage 3: sums of squares.
    pay_t                       pay3_reg;
    logic                       zero3_reg, fars3_reg, fare3_reg;
    logic [63:0]                dsum3_reg, esum3_reg;
    logic [65:0]                vsum3_reg;
    logic [61:0]                r2_3_reg;
    logic [AXES-1:0][COORD_W:0] mv3_reg;
    logic [AXES-1:0]            vneg3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay3_reg  <= pay2_reg;
            zero3_reg <= zero2_reg;
            fars3_reg <= fars2_reg;
            fare3_reg <= fare2_reg;
            dsum3_reg <= {2'd0, sqs2_reg[0]} + {2'd0, sqs2_reg[1]} + {2'd0, sqs2_reg[2]};
            esum3_reg <= {2'd0, sqe2_reg[0]} + {2'd0, sqe2_reg[1]} + {2'd0, sqe2_reg[2]};
            vsum3_reg <= sqv2_reg[0] + sqv2_reg[1] + sqv2_reg[2];
            r2_3_reg  <= r2_2_reg;
            mv3_reg   <= mv2_reg;
            vneg3_reg <= vneg2_reg;
        end
    end

    // Stage 4: inside tests, outcome, square root operands.
    logic       in_s, in_e;
    logic [1:0] outc4;
    logic [63:0] slack4;

    always_comb begin
        in_s = ~fars3_reg && (dsum3_reg < {2'd0, r2_3_reg});
        in_e = ~fare3_reg && (esum3_reg < {2'd0, r2_3_reg});
        if (zero3_reg) begin
            outc4 = TRIM_ZERO;
        end else if (in_s) begin
            outc4 = TRIM_START;
        end else if (in_e) begin
            outc4 = TRIM_END;
        end else begin
            outc4 = TRIM_NONE;
        end
        slack4 = {2'd0, r2_3_reg} - (in_s ? dsum3_reg : esum3_reg);
    end

    mid_t        mid4_reg;
    logic [63:0] slack4_reg, quart4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mid4_reg.pay     <= pay3_reg;
            mid4_reg.outcome <= outc4;
            mid4_reg.mag     <= mv3_reg;
            // The end moves toward the start, so its direction is -v.
            mid4_reg.neg     <= (outc4 == TRIM_END) ? ~vneg3_reg : vneg3_reg;
            slack4_reg       <= slack4;
            quart4_reg       <= vsum3_reg[65:2];
        end
    end

    // Stages 5 to 36: two square roots side by side.
    logic [31:0] root_h, root_q;
    mid_t        mid_reg [SQRT_STEPS];

    sst_isqrt u_sqrt_h (
        .aclk (aclk),
        .en   (adv),
        .x_in (slack4_reg),
        .root (root_h)
    );

    sst_isqrt u_sqrt_q (
        .aclk (aclk),
        .en   (adv),
        .x_in (quart4_reg),
        .root (root_q)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            mid_reg[0] <= mid4_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                mid_reg[k] <= mid_reg[k-1];
            end
        end
    end

    // Stage 37: step numerators and segment length (2*root+1, never zero).
    tail_t                 t37_reg;
    logic [AXES-1:0][64:0] prod37_reg;
    logic [32:0]           len37_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t37_reg.pay     <= mid_reg[SQRT_STEPS-1].pay;
            t37_reg.outcome <= mid_reg[SQRT_STEPS-1].outcome;
            t37_reg.neg     <= mid_reg[SQRT_STEPS-1].neg;
            for (int i = 0; i < AXES; i++) begin
                prod37_reg[i] <= mid_reg[SQRT_STEPS-1].mag[i] * {1'b0, root_h};
            end
            len37_reg <= {root_q, 1'b1};
        end
    end

    // Stage 38: add half the divisor for rounding and split the dividend.
    logic [AXES-1:0][65:0] num38;
    tail_t                 t38_reg;
    logic [AXES-1:0][32:0] rem38_reg;
    logic [AXES-1:0][31:0] low38_reg;
    logic [32:0]           len38_reg;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            num38[i] = {1'b0, prod37_reg[i]} + {34'd0, len37_reg[32:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t38_reg   <= t37_reg;
            len38_reg <= len37_reg;
            for (int i = 0; i < AXES; i++) begin
                rem38_reg[i] <= num38[i][64:32];
                low38_reg[i] <= num38[i][31:0];
            end
        end
    end

    // Stages 39 to 70: one divider lane per axis.
    logic [AXES-1:0][31:0] quo;
    tail_t                 tail_reg [DIV_STEPS];

    for (genvar i = 0; i < AXES; i++) begin : g_lane
        sst_div u_div (
            .aclk   (aclk),
            .en     (adv),
            .den_in (len38_reg),
            .rem_in (rem38_reg[i]),
            .low_in (low38_reg[i]),
            .quo    (quo[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tail_reg[0] <= t38_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    // Stage 71: apply the step with saturation and register the result.
    tail_t                        tl;
    logic [AXES-1:0][COORD_W-1:0] mover, moved;
    logic [AXES-1:0][33:0]        sum;
    pay_t                         res;

    always_comb begin
        tl    = tail_reg[DIV_STEPS-1];
        mover = (tl.outcome == TRIM_END) ? tl.pay.e : tl.pay.s;
        for (int i = 0; i < AXES; i++) begin
            sum[i] = {{2{mover[i][31]}}, mover[i]}
                   + (tl.neg[i] ? (~{2'd0, quo[i]} + 34'd1) : {2'd0, quo[i]});
            if (sum[i][33:31] == 3'b000 || sum[i][33:31] == 3'b111) begin
                moved[i] = sum[i][31:0];
            end else if (sum[i][33]) begin
                moved[i] = 32'h8000_0000;
            end else begin
                moved[i] = 32'h7FFF_FFFF;
            end
        end
        res = tl.pay;
        if (tl.outcome == TRIM_START) begin
            res.s = moved;
        end else if (tl.outcome == TRIM_END) begin
            res.e = moved;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= res;
            m_tuser <= tl.outcome;
        end
    end

endmodule

// File: rtl/core/sst_checker.sv
module sst_checker import sst_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result word dropped");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // A zero-length segment comes back with both endpoints equal.
    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == TRIM_ZERO |-> m_tdata[95:0] == m_tdata[191:96])
        else $error("zero-length outcome with distinct endpoints");

    // While a result waits, the input side must also be held.
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the pipeline is stalled");

endmodule

bind segment_sphere_trim_unit sst_checker u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/tb_segment_sphere_trim_unit.sv
`timescale 1ns / 1ps

module tb_segment_sphere_trim_unit;
    import sst_pkg::*;

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 400000;

    typedef longint triple_t [3];

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
        logic [30:0]        rad;
    } seg_t;

    typedef struct {
        logic [31:0] coord [6];
        logic [1:0]  outcome;
    } trim_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;

    trim_t  trims_pending [$];
    int     err_count;
    int     cycles;
    int     idle_pct;
    int     stall_pct;

    segment_sphere_trim_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag_of(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Strictly inside: each axis offset below 2^31 and squared distance below r^2.
    function automatic bit strictly_inside(input triple_t p, input triple_t c,
                                           input logic [63:0] r, output logic [63:0] slack);
        logic [63:0] dist2;
        logic [63:0] m;
        dist2 = 0;
        slack = 0;
        for (int i = 0; i < 3; i++) begin
            m = mag_of(p[i] - c[i]);
            if (m >= 64'h8000_0000) return 1'b0;
            dist2 = dist2 + m * m;
        end
        if (dist2 >= r * r) return 1'b0;
        slack = r * r - dist2;
        return 1'b1;
    endfunction

    function automatic void shift_toward(ref triple_t mv, input triple_t other,
                                         input logic [63:0] h);
        logic [63:0] mags [3];
        logic [65:0] len2;
        logic [63:0] len;
        logic [63:0] q;
        longint      moved;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            mags[i] = mag_of(other[i] - mv[i]);
            len2    = len2 + 66'(mags[i]) * 66'(mags[i]);
        end
        len = 2 * int_sqrt(len2[65:2]) + 1;
        for (int i = 0; i < 3; i++) begin
            q     = (mags[i] * h + (len >> 1)) / len;
            moved = (other[i] < mv[i]) ? mv[i] - longint'(q) : mv[i] + longint'(q);
            if (moved > 64'sd2147483647) moved = 64'sd2147483647;
            if (moved < -64'sd2147483648) moved = -64'sd2147483648;
            mv[i] = moved;
        end
    endfunction

    function automatic trim_t trim_predict(input seg_t w);
        triple_t     s, e, c;
        logic [63:0] slack;
        trim_t       t;
        s = '{longint'(w.sx), longint'(w.sy), longint'(w.sz)};
        e = '{longint'(w.ex), longint'(w.ey), longint'(w.ez)};
        c = '{longint'(w.cx), longint'(w.cy), longint'(w.cz)};
        t.outcome = TRIM_NONE;
        if (s[0] == e[0] && s[1] == e[1] && s[2] == e[2]) begin
            t.outcome = TRIM_ZERO;
        end else if (strictly_inside(s, c, 64'(w.rad), slack)) begin
            shift_toward(s, e, int_sqrt(slack));
            t.outcome = TRIM_START;
        end else if (strictly_inside(e, c, 64'(w.rad), slack)) begin
            shift_toward(e, s, int_sqrt(slack));
            t.outcome = TRIM_END;
        end
        for (int i = 0; i < 3; i++) begin
            t.coord[i]     = s[i][31:0];
            t.coord[3 + i] = e[i][31:0];
        end
        return t;
    endfunction

    task automatic send_word(input seg_t w);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w.rad, w.cz, w.cy, w.cx, w.ez, w.ey, w.ex, w.sz, w.sy, w.sx};
        do @(posedge aclk); while (!s_tready);
        trims_pending.push_back(trim_predict(w));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (trims_pending.size() != 0) @(posedge aclk);
    endtask

    function automatic seg_t make_seg(input logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                      cx, cy, cz, input logic [30:0] rad);
        seg_t w;
        w = '{sx, sy, sz, ex, ey, ez, cx, cy, cz, rad};
        return w;
    endfunction

    // Point near the center, offset by up to about span per axis (wraps at the extremes).
    function automatic logic signed [31:0] near(input logic signed [31:0] c,
                                                input logic [30:0] span);
        longint off;
        off = longint'($urandom_range(32'(span))) - longint'($urandom_range(32'(span)));
        return 32'(longint'(c) + off);
    endfunction

    function automatic seg_t random_seg();
        seg_t        w;
        logic [30:0] rad;
        int          kind;
        kind = $urandom_range(9);
        rad  = 31'($urandom) >> $urandom_range(30);
        w.cx = $urandom; w.cy = $urandom; w.cz = $urandom;
        w.rad = rad;
        if (kind == 0) begin
            w = make_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, 31'($urandom));
        end else begin
            w.sx = near(w.cx, rad); w.sy = near(w.cy, rad); w.sz = near(w.cz, rad);
            if (kind < 4) begin
                w.ex = $urandom; w.ey = $urandom; w.ez = $urandom;
            end else begin
                w.ex = near(w.cx, rad); w.ey = near(w.cy, rad); w.ez = near(w.cz, rad);
            end
            if (kind == 4) begin
                {w.sx, w.sy, w.sz} = {w.ex, w.ey, w.ez};
            end else if (kind == 5) begin
                w.sx = $urandom;
            end else if (kind == 6) begin
                {w.sx, w.ex} = {w.ex, w.sx};
                w.ex = w.ex ^ 32'h4000_0000;
            end
        end
        return w;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        trim_t  want;
        logic [31:0] got;
        string  names [6];
        names = '{"new_start_x", "new_start_y", "new_start_z",
                  "new_end_x", "new_end_y", "new_end_z"};
        if (aresetn && m_tvalid && m_tready) begin
            if (trims_pending.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
            end else begin
                want = trims_pending.pop_front();
                for (int i = 0; i < 6; i++) begin
                    got = m_tdata[32 * i +: 32];
                    if (got !== want.coord[i]) begin
                        $error("%s: expected %0d, got %0d", names[i],
                               $signed(want.coord[i]), $signed(got));
                        err_count++;
                    end
                end
                if (m_tuser !== want.outcome) begin
                    $error("trim_outcome: expected %0d, got %0d", want.outcome, m_tuser);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_segment_sphere_trim_unit: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINC = 32'sh8000_0000;
        localparam logic [30:0]        MAXR = 31'h7FFF_FFFF;
        // Zero length, inside and outside.
        send_word(make_seg(5, 6, 7, 5, 6, 7, 0, 0, 0, 31'h10_0000));
        send_word(make_seg(MAXC, MINC, 0, MAXC, MINC, 0, 0, 0, 0, 31'd1));
        // Start inside, end inside, both inside.
        send_word(make_seg(0, 0, 0, 32'sh50_0000, 0, 0, 0, 0, 0, 31'h2_0000));
        send_word(make_seg(32'sh50_0000, 32'sh1_0000, 0, 32'sh100, 0, 0, 0, 0, 0,
                           31'h2_0000));
        send_word(make_seg(32'sh100, 0, 0, -32'sh100, 0, 32'sh80, 0, 0, 0, 31'h2_0000));
        // On the surface counts as outside.
        send_word(make_seg(32'sh2_0000, 0, 0, 32'sh9_0000, 0, 0, 0, 0, 0, 31'h2_0000));
        send_word(make_seg(32'sh9_0000, 0, 0, 0, 32'sh2_0000, 0, 0, 0, 0, 31'h2_0000));
        // Far axis offsets and radius extremes.
        send_word(make_seg(MAXC, 0, 0, MINC, 0, 0, MINC, 0, 0, MAXR));
        send_word(make_seg(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXR));
        send_word(make_seg(0, 0, 0, 1, 0, 0, 0, 0, 0, 31'd0));
        send_word(make_seg(0, 0, 0, 1, 0, 0, 0, 0, 0, 31'd1));
        // Large moves near the coordinate limits.
        send_word(make_seg(MAXC - 5, MAXC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXR));
        send_word(make_seg(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC + 9, MINC, MINC, MAXR));
        send_word(make_seg(MAXC, 0, 0, MAXC - 1, 0, 0, MAXC, 0, 0, MAXR));
        send_word(make_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 0, 0, 31'd0));
        send_word(make_seg(-1, -1, -1, 0, 0, 0, -1, -1, -1, MAXR));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_word(random_seg());
        // Hold off the sender until the pipeline has emptied.
        wait_drained();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(420, 0, 0);
        test_random(410, 66, 0);
        test_random(410, 0, 66);
        test_random(410, 32, 32);

        repeat (LATENCY + 10) @(posedge aclk);
        if (err_count == 0 && trims_pending.size() == 0) begin
            $display("tb_segment_sphere_trim_unit: PASS");
        end else begin
            $display("tb_segment_sphere_trim_unit: FAIL");
        end
        $finish;
    end

endmodule
